>>> src/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types, command codes, flash opcodes and beat lookup for the serial
// flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    // page geometry: linear address -> page number above the byte offset
    localparam int PAGE_BYTES  = 512;
    localparam int PAGE_SHIFT  = 10;
    localparam int OFFSET_BITS = $clog2(PAGE_BYTES);

    // field widths
    localparam int CMD_W      = 4;
    localparam int ADDR_W     = 21;
    localparam int SPI_ADDR_W = 24;
    localparam int IDX_W      = 3;
    localparam int SEL_W      = 2;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // host request codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ       = 4'd0,
        CMD_WRITE      = 4'd1,
        CMD_DATA       = 4'd2,
        CMD_SLOT       = 4'd3,
        CMD_END        = 4'd4,
        CMD_PAGE_ERASE = 4'd5,
        CMD_CHIP_ERASE = 4'd6,
        CMD_ID         = 4'd7,
        CMD_STATUS     = 4'd8,
        CMD_PROT_EN    = 4'd9,
        CMD_PROT_DIS   = 4'd10,
        CMD_PREG_ERASE = 4'd11,
        CMD_PREG_PROG  = 4'd12,
        CMD_PREG_READ  = 4'd13
    } cmd_t;

    // flash opcodes and fill bytes
    localparam logic [7:0] OP_READ       = 8'hE8;
    localparam logic [7:0] OP_WRITE      = 8'h82;
    localparam logic [7:0] OP_DUMMY      = 8'hA5;
    localparam logic [7:0] OP_PAGE_ERASE = 8'h81;
    localparam logic [7:0] OP_ID         = 8'h9F;
    localparam logic [7:0] OP_STATUS     = 8'hD7;
    localparam logic [7:0] SLOT_FILL     = 8'h00;

    // fixed four-byte command sequences
    localparam logic [7:0] CHIP_ERASE_SEQ [4] = '{8'hC7, 8'h94, 8'h80, 8'h9A};
    localparam logic [7:0] PROT_EN_SEQ    [4] = '{8'h3D, 8'h2A, 8'h7F, 8'hA9};
    localparam logic [7:0] PROT_DIS_SEQ   [4] = '{8'h3D, 8'h2A, 8'h7F, 8'h9A};
    localparam logic [7:0] PREG_ERASE_SEQ [4] = '{8'h3D, 8'h2A, 8'h7F, 8'hCF};
    localparam logic [7:0] PREG_PROG_SEQ  [4] = '{8'h3D, 8'h2A, 8'h7F, 8'hFC};
    localparam logic [7:0] PREG_READ_SEQ  [4] = '{8'h32, 8'h2A, 8'h7F, 8'hFC};

    // one classified request as handed from front to back
    typedef struct packed {
        cmd_t                  cmd;
        logic                  err;
        logic [SPI_ADDR_W-1:0] addr;
        logic [7:0]            data;
        logic [SEL_W-1:0]      sel;
        logic                  prot;
        logic                  rel_last;
        logic [IDX_W-1:0]      last_idx;
    } job_t;

    // byte-level content of one transfer
    typedef struct packed {
        logic [7:0] tx;
        logic       byte_valid;
        logic       capture;
    } beat_t;

    // address byte for beats one to three, most significant first
    function automatic logic [7:0] addr_byte(logic [SPI_ADDR_W-1:0] addr,
                                             logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd1:    b = addr[23:16];
            3'd2:    b = addr[15:8];
            default: b = addr[7:0];
        endcase
        return b;
    endfunction

    // transfer content for beat idx of a request
    function automatic beat_t job_beat(job_t job, logic [IDX_W-1:0] idx);
        beat_t b;
        b.tx         = SLOT_FILL;
        b.byte_valid = 1'b0;
        b.capture    = 1'b0;
        if (!job.err) begin
            b.byte_valid = 1'b1;
            case (job.cmd)
                CMD_READ: begin
                    if (idx == 3'd0)
                        b.tx = OP_READ;
                    else if (idx < 3'd4)
                        b.tx = addr_byte(job.addr, idx);
                    else
                        b.tx = OP_DUMMY;
                end
                CMD_WRITE:
                    b.tx = (idx == 3'd0) ? OP_WRITE : addr_byte(job.addr, idx);
                CMD_PAGE_ERASE:
                    b.tx = (idx == 3'd0) ? OP_PAGE_ERASE : addr_byte(job.addr, idx);
                CMD_DATA:
                    b.tx = job.data;
                CMD_SLOT:
                    b.capture = 1'b1;
                CMD_END:
                    b.byte_valid = 1'b0;
                CMD_CHIP_ERASE:
                    b.tx = CHIP_ERASE_SEQ[idx[1:0]];
                CMD_ID, CMD_STATUS: begin
                    if (idx == 3'd0)
                        b.tx = (job.cmd == CMD_ID) ? OP_ID : OP_STATUS;
                    else
                        b.capture = 1'b1;
                end
                CMD_PROT_EN:
                    b.tx = PROT_EN_SEQ[idx[1:0]];
                CMD_PROT_DIS:
                    b.tx = PROT_DIS_SEQ[idx[1:0]];
                CMD_PREG_ERASE:
                    b.tx = PREG_ERASE_SEQ[idx[1:0]];
                CMD_PREG_PROG:
                    b.tx = (idx == 3'd4) ? job.data : PREG_PROG_SEQ[idx[1:0]];
                CMD_PREG_READ:
                    b.tx = PREG_READ_SEQ[idx[1:0]];
                default:
                    b.byte_valid = 1'b0;
            endcase
        end
        return b;
    endfunction

endpackage

>>> src/sfcs_front.sv
// ----------------------------------------------------------------------------
// sfcs_front
// Takes host requests, checks them against the frame state, tracks write
// protect and chip select, and turns each into a job for the back end.
// ----------------------------------------------------------------------------
module sfcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfcs_pkg::SEL_W-1:0]    cfg_wdata,
    input  logic                          req_valid,
    input  logic                          queue_full,
    input  logic [sfcs_pkg::CMD_W-1:0]    command,
    input  logic [sfcs_pkg::ADDR_W-1:0]   address,
    input  logic [7:0]                    data,
    output logic                          push,
    output sfcs_pkg::job_t                job
);

    logic [sfcs_pkg::SEL_W-1:0]        chip_line_reg;
    logic                              frame_open_reg;
    logic                              frame_open_next;
    logic                              protect_off_reg;
    logic                              protect_off_next;

    logic                              known;
    logic                              in_frame;
    logic                              is_start;
    logic                              err;
    logic                              releases;
    logic                              relocks;
    logic                              opens;
    logic                              prot_during;
    logic                              frame_after;
    logic [sfcs_pkg::IDX_W-1:0]        last_idx;
    logic [sfcs_pkg::SPI_ADDR_W-1:0]   mapped;
    logic [sfcs_pkg::OFFSET_BITS-1:0]  offset;
    logic [sfcs_pkg::ADDR_W-sfcs_pkg::OFFSET_BITS-1:0] page;

    // a request is taken whenever the queue has room
    assign push = req_valid && !queue_full;

    // classify the request
    always_comb
    begin
        known    = (command <= sfcs_pkg::CMD_PREG_READ);
        in_frame = command inside {sfcs_pkg::CMD_DATA, sfcs_pkg::CMD_SLOT,
                                   sfcs_pkg::CMD_END};
        is_start = known && !in_frame;
        err      = !known || (is_start && frame_open_reg)
                   || (in_frame && !frame_open_reg);
        releases = command inside {sfcs_pkg::CMD_WRITE, sfcs_pkg::CMD_PAGE_ERASE,
                                   sfcs_pkg::CMD_CHIP_ERASE, sfcs_pkg::CMD_PREG_ERASE,
                                   sfcs_pkg::CMD_PREG_PROG};
        relocks  = command inside {sfcs_pkg::CMD_END, sfcs_pkg::CMD_PAGE_ERASE,
                                   sfcs_pkg::CMD_CHIP_ERASE, sfcs_pkg::CMD_PREG_ERASE};
        opens    = command inside {sfcs_pkg::CMD_READ, sfcs_pkg::CMD_WRITE,
                                   sfcs_pkg::CMD_PREG_PROG, sfcs_pkg::CMD_PREG_READ};
    end

    // frame and protect state after this request
    always_comb
    begin
        prot_during = protect_off_reg || (!err && releases);
        if (err)
            frame_after = frame_open_reg;
        else if (opens)
            frame_after = 1'b1;
        else if (command == sfcs_pkg::CMD_END)
            frame_after = 1'b0;
        else
            frame_after = frame_open_reg;

        frame_open_next  = frame_open_reg;
        protect_off_next = protect_off_reg;
        if (push && !err) begin
            frame_open_next  = frame_after;
            protect_off_next = relocks ? 1'b0 : prot_during;
        end
    end

    // number of transfers the request produces, minus one
    always_comb
    begin
        if (err) begin
            last_idx = 3'd0;
        end else begin
            case (command)
                sfcs_pkg::CMD_READ:                         last_idx = 3'd7;
                sfcs_pkg::CMD_DATA, sfcs_pkg::CMD_SLOT,
                sfcs_pkg::CMD_END:                          last_idx = 3'd0;
                sfcs_pkg::CMD_ID, sfcs_pkg::CMD_PREG_PROG:  last_idx = 3'd4;
                sfcs_pkg::CMD_STATUS:                       last_idx = 3'd1;
                default:                                    last_idx = 3'd3;
            endcase
        end
    end

    // page-mapped address: page number shifted above the byte offset
    always_comb
    begin
        offset = address[sfcs_pkg::OFFSET_BITS-1:0];
        page   = address[sfcs_pkg::ADDR_W-1:sfcs_pkg::OFFSET_BITS];
        mapped = sfcs_pkg::SPI_ADDR_W'(offset)
                 | (sfcs_pkg::SPI_ADDR_W'(page) << sfcs_pkg::PAGE_SHIFT);
    end

    // job handed to the queue
    always_comb
    begin
        job.cmd      = sfcs_pkg::cmd_t'(command);
        job.err      = err;
        job.addr     = (command == sfcs_pkg::CMD_PAGE_ERASE)
                       ? sfcs_pkg::SPI_ADDR_W'(address) : mapped;
        job.data     = data;
        job.sel      = chip_line_reg;
        job.prot     = prot_during;
        job.rel_last = !err && !frame_after;
        job.last_idx = last_idx;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chip_line_reg   <= '0;
            frame_open_reg  <= 1'b0;
            protect_off_reg <= 1'b0;
        end else begin
            if (cfg_we)
                chip_line_reg <= cfg_wdata;
            frame_open_reg  <= frame_open_next;
            protect_off_reg <= protect_off_next;
        end
    end

endmodule

>>> src/sfcs_queue.sv
// ----------------------------------------------------------------------------
// sfcs_queue
// Small first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module sfcs_queue #(
    parameter int DEPTH = sfcs_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfcs_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output sfcs_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfcs_pkg::job_t     slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_job;
    end

endmodule

>>> src/sfcs_back.sv
// ----------------------------------------------------------------------------
// sfcs_back
// Walks the job at the head of the queue one transfer per cycle, while the
// result stage is not stalled, into a registered result stage.
// ----------------------------------------------------------------------------
module sfcs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  sfcs_pkg::job_t              head_job,
    output logic                        pop,
    input  logic                        rsp_stall,
    output logic                        rsp_valid,
    output logic [7:0]                  tx_byte,
    output logic                        byte_valid,
    output logic [sfcs_pkg::SEL_W-1:0]  select_line,
    output logic                        release_after,
    output logic                        capture,
    output logic                        protect_released,
    output logic                        request_error,
    output logic                        last
);

    logic                        rsp_valid_reg;
    logic [sfcs_pkg::IDX_W-1:0]  idx_reg;
    logic [sfcs_pkg::IDX_W-1:0]  idx_next;
    logic                        load;
    logic                        at_last;
    sfcs_pkg::beat_t             beat;

    logic [7:0]                  tx_byte_reg;
    logic                        byte_valid_reg;
    logic [sfcs_pkg::SEL_W-1:0]  select_line_reg;
    logic                        release_after_reg;
    logic                        capture_reg;
    logic                        protect_released_reg;
    logic                        request_error_reg;
    logic                        last_reg;

    // result slot is free or being emptied this cycle
    assign load    = head_valid && (!rsp_valid_reg || !rsp_stall);
    assign at_last = (idx_reg == head_job.last_idx);
    assign pop     = load && at_last;
    assign beat    = sfcs_pkg::job_beat(head_job, idx_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = at_last ? '0 : idx_reg + 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            idx_reg <= idx_next;
            if (load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            tx_byte_reg          <= beat.tx;
            byte_valid_reg       <= beat.byte_valid;
            capture_reg          <= beat.capture;
            select_line_reg      <= head_job.sel;
            release_after_reg    <= at_last && head_job.rel_last;
            protect_released_reg <= head_job.prot;
            request_error_reg    <= head_job.err;
            last_reg             <= at_last;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign tx_byte          = tx_byte_reg;
    assign byte_valid       = byte_valid_reg;
    assign select_line      = select_line_reg;
    assign release_after    = release_after_reg;
    assign capture          = capture_reg;
    assign protect_released = protect_released_reg;
    assign request_error    = request_error_reg;
    assign last             = last_reg;

endmodule

>>> src/serial_flash_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// serial_flash_command_sequencer_core
// Turns host requests into SPI byte transfers for a page-oriented serial
// data flash.
// ----------------------------------------------------------------------------
// Each accepted request yields one to eight result transfers (read: 8,
// id and protect register program: 5, status: 2, frame data, read slot,
// end and rejected requests: 1, all others: 4), delivered one per clock
// while rsp_stall is low from a registered result stage. The front end
// takes a request every clock while the job queue (four entries by
// default) has room, so throughput is set by the back end walking one
// transfer per cycle. After acceptance each request passes through the
// job queue and then the registered result stage.
// Frame state, write protect and the select line are tracked at
// acceptance, so chip_line changes apply to requests accepted afterwards.
module serial_flash_command_sequencer_core #(
    parameter int QUEUE_DEPTH = sfcs_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfcs_pkg::SEL_W-1:0]    cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [sfcs_pkg::CMD_W-1:0]    command,
    input  logic [sfcs_pkg::ADDR_W-1:0]   address,
    input  logic [7:0]                    data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [7:0]                    tx_byte,
    output logic                          byte_valid,
    output logic [sfcs_pkg::SEL_W-1:0]    select_line,
    output logic                          release_after,
    output logic                          capture,
    output logic                          protect_released,
    output logic                          request_error,
    output logic                          last
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           head_valid;
    sfcs_pkg::job_t push_job;
    sfcs_pkg::job_t head_job;

    assign req_stall = queue_full;

    // request classification and frame state
    sfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .queue_full (queue_full),
        .command    (command),
        .address    (address),
        .data       (data),
        .push       (push),
        .job        (push_job)
    );

    // job queue
    sfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // transfer sequencing and result stage
    sfcs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_job         (head_job),
        .pop              (pop),
        .rsp_stall        (rsp_stall),
        .rsp_valid        (rsp_valid),
        .tx_byte          (tx_byte),
        .byte_valid       (byte_valid),
        .select_line      (select_line),
        .release_after    (release_after),
        .capture          (capture),
        .protect_released (protect_released),
        .request_error    (request_error),
        .last             (last)
    );

endmodule
